>>> hw/rtl/jbt_pkg.sv
package jbt_pkg;

    // Lexer mode
    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_STRING  = 3'd1,
        MODE_NUMBER  = 3'd2,
        MODE_KEYWORD = 3'd3,
        MODE_ERROR   = 3'd4
    } t_mode;

    // Token kinds
    localparam logic [3:0] KIND_LBRACE   = 4'd0;
    localparam logic [3:0] KIND_RBRACE   = 4'd1;
    localparam logic [3:0] KIND_LBRACKET = 4'd2;
    localparam logic [3:0] KIND_RBRACKET = 4'd3;
    localparam logic [3:0] KIND_COLON    = 4'd4;
    localparam logic [3:0] KIND_COMMA    = 4'd5;
    localparam logic [3:0] KIND_STRING   = 4'd6;
    localparam logic [3:0] KIND_NUMBER   = 4'd7;
    localparam logic [3:0] KIND_TRUE     = 4'd8;
    localparam logic [3:0] KIND_FALSE    = 4'd9;
    localparam logic [3:0] KIND_NULL     = 4'd10;

    // Error codes
    localparam logic [1:0] ERR_NONE         = 2'd0;
    localparam logic [1:0] ERR_UNEXPECTED   = 2'd1;
    localparam logic [1:0] ERR_UNTERMINATED = 2'd2;

    // Keyword selects
    localparam logic [1:0] KW_TRUE  = 2'd0;
    localparam logic [1:0] KW_FALSE = 2'd1;
    localparam logic [1:0] KW_NULL  = 2'd2;

    // Characters
    localparam logic [7:0] CH_LBRACE   = 8'h7B;
    localparam logic [7:0] CH_RBRACE   = 8'h7D;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_COLON    = 8'h3A;
    localparam logic [7:0] CH_COMMA    = 8'h2C;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] CH_MINUS    = 8'h2D;
    localparam logic [7:0] CH_DOT      = 8'h2E;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;
    localparam logic [7:0] CH_T        = 8'h74;
    localparam logic [7:0] CH_F        = 8'h66;
    localparam logic [7:0] CH_N        = 8'h6E;
    localparam logic [7:0] CH_R        = 8'h72;
    localparam logic [7:0] CH_U        = 8'h75;
    localparam logic [7:0] CH_E        = 8'h65;
    localparam logic [7:0] CH_A        = 8'h61;
    localparam logic [7:0] CH_L        = 8'h6C;
    localparam logic [7:0] CH_S        = 8'h73;

    // One result item
    typedef struct packed {
        logic [3:0] token_kind;
        logic [7:0] content_byte;
        logic       content_valid;
        logic       token_end;
        logic [1:0] error_code;
    } t_item;

    // Results caused by one input byte
    typedef struct packed {
        t_item first;
        t_item second;
        logic  two;
    } t_pair;

    // Outcome of lexing a byte from idle
    typedef struct packed {
        logic  emit;
        t_item item;
        t_mode mode;
        logic  kw_load;
    } t_idle_res;

    localparam t_item ITEM_NONE = '{4'd0, 8'd0, 1'b0, 1'b0, ERR_NONE};

    function automatic t_item make_item(input logic [3:0] kind, input logic [7:0] cbyte,
                                        input logic cvalid, input logic tend,
                                        input logic [1:0] err);
        t_item it;
        it.token_kind    = kind;
        it.content_byte  = cbyte;
        it.content_valid = cvalid;
        it.token_end     = tend;
        it.error_code    = err;
        return it;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // Keyword length; an unused select falls back to true
    function automatic logic [2:0] kw_len(input logic [1:0] sel);
        logic [2:0] len;
        unique case (sel)
            KW_FALSE: len = 3'd5;
            default:  len = 3'd4;
        endcase
        return len;
    endfunction

    function automatic logic [3:0] kw_kind(input logic [1:0] sel);
        logic [3:0] kind;
        unique case (sel)
            KW_FALSE: kind = KIND_FALSE;
            KW_NULL:  kind = KIND_NULL;
            default:  kind = KIND_TRUE;
        endcase
        return kind;
    endfunction

    // Expected letter at a position of a keyword
    function automatic logic [7:0] kw_char(input logic [1:0] sel, input logic [2:0] pos);
        logic [7:0] ch;
        ch = 8'd0;
        unique case (sel)
            KW_FALSE: begin
                unique case (pos)
                    3'd0:    ch = CH_F;
                    3'd1:    ch = CH_A;
                    3'd2:    ch = CH_L;
                    3'd3:    ch = CH_S;
                    3'd4:    ch = CH_E;
                    default: ch = 8'd0;
                endcase
            end
            KW_NULL: begin
                unique case (pos)
                    3'd0:    ch = CH_N;
                    3'd1:    ch = CH_U;
                    3'd2:    ch = CH_L;
                    3'd3:    ch = CH_L;
                    default: ch = 8'd0;
                endcase
            end
            default: begin
                unique case (pos)
                    3'd0:    ch = CH_T;
                    3'd1:    ch = CH_R;
                    3'd2:    ch = CH_U;
                    3'd3:    ch = CH_E;
                    default: ch = 8'd0;
                endcase
            end
        endcase
        return ch;
    endfunction

    // Lex one byte from idle: at most one item
    function automatic t_idle_res lex_idle(input logic [7:0] c, input logic last);
        t_idle_res r;
        r.emit    = 1'b0;
        r.item    = ITEM_NONE;
        r.mode    = MODE_IDLE;
        r.kw_load = 1'b0;
        unique case (c)
            CH_LBRACE: begin
                r.emit = 1'b1;
                r.item = make_item(KIND_LBRACE, 8'd0, 1'b0, 1'b1, ERR_NONE);
            end
            CH_RBRACE: begin
                r.emit = 1'b1;
                r.item = make_item(KIND_RBRACE, 8'd0, 1'b0, 1'b1, ERR_NONE);
            end
            CH_LBRACKET: begin
                r.emit = 1'b1;
                r.item = make_item(KIND_LBRACKET, 8'd0, 1'b0, 1'b1, ERR_NONE);
            end
            CH_RBRACKET: begin
                r.emit = 1'b1;
                r.item = make_item(KIND_RBRACKET, 8'd0, 1'b0, 1'b1, ERR_NONE);
            end
            CH_COLON: begin
                r.emit = 1'b1;
                r.item = make_item(KIND_COLON, 8'd0, 1'b0, 1'b1, ERR_NONE);
            end
            CH_COMMA: begin
                r.emit = 1'b1;
                r.item = make_item(KIND_COMMA, 8'd0, 1'b0, 1'b1, ERR_NONE);
            end
            CH_SPACE, CH_LF, CH_CR, CH_TAB: begin
                r.emit = 1'b0;
            end
            CH_QUOTE: begin
                if (last) begin
                    r.emit = 1'b1;
                    r.item = make_item(4'd0, 8'd0, 1'b0, 1'b0, ERR_UNTERMINATED);
                end else begin
                    r.mode = MODE_STRING;
                end
            end
            CH_T, CH_F, CH_N: begin
                if (last) begin
                    r.emit = 1'b1;
                    r.item = make_item(4'd0, c, 1'b0, 1'b0, ERR_UNEXPECTED);
                end else begin
                    r.mode    = MODE_KEYWORD;
                    r.kw_load = 1'b1;
                end
            end
            default: begin
                r.emit = 1'b1;
                if (is_digit(c) || (c == CH_MINUS)) begin
                    r.mode = MODE_NUMBER;
                    r.item = make_item(KIND_NUMBER, c, 1'b1, 1'b0, ERR_NONE);
                end else begin
                    r.mode = MODE_ERROR;
                    r.item = make_item(4'd0, c, 1'b0, 1'b0, ERR_UNEXPECTED);
                end
            end
        endcase
        return r;
    endfunction

endpackage

>>> hw/rtl/jbt_lexer.sv
module jbt_lexer (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_data_byte,
    input  logic          i_end_of_input,
    output logic          o_push,
    output jbt_pkg::t_pair o_pair
);

    jbt_pkg::t_mode     r_mode, n_mode;
    logic [1:0]         r_kw_sel, n_kw_sel;
    logic [2:0]         r_kw_pos, n_kw_pos;
    logic [7:0]         r_kw_first, n_kw_first;

    jbt_pkg::t_idle_res idle_res;
    logic               num_char;
    logic               kw_match;
    logic [2:0]         kw_pos_inc;
    logic [1:0]         item_cnt;

    // Shared decode terms
    assign idle_res   = jbt_pkg::lex_idle(i_data_byte, i_end_of_input);
    assign num_char   = jbt_pkg::is_digit(i_data_byte) || (i_data_byte == jbt_pkg::CH_DOT);
    assign kw_pos_inc = r_kw_pos + 3'd1;
    assign kw_match   = (r_kw_pos < jbt_pkg::kw_len(r_kw_sel)) &&
                        (i_data_byte == jbt_pkg::kw_char(r_kw_sel, r_kw_pos));

    // Next state
    always_comb begin
        n_mode     = r_mode;
        n_kw_sel   = r_kw_sel;
        n_kw_pos   = r_kw_pos;
        n_kw_first = r_kw_first;
        unique case (r_mode)
            jbt_pkg::MODE_STRING: begin
                if (i_data_byte == jbt_pkg::CH_QUOTE) begin
                    n_mode = jbt_pkg::MODE_IDLE;
                end
            end
            jbt_pkg::MODE_NUMBER, jbt_pkg::MODE_IDLE: begin
                if ((r_mode == jbt_pkg::MODE_IDLE) || !num_char) begin
                    n_mode = idle_res.mode;
                    if (idle_res.kw_load) begin
                        n_kw_pos   = 3'd1;
                        n_kw_first = i_data_byte;
                        if (i_data_byte == jbt_pkg::CH_T) begin
                            n_kw_sel = jbt_pkg::KW_TRUE;
                        end else if (i_data_byte == jbt_pkg::CH_F) begin
                            n_kw_sel = jbt_pkg::KW_FALSE;
                        end else begin
                            n_kw_sel = jbt_pkg::KW_NULL;
                        end
                    end
                end
            end
            jbt_pkg::MODE_KEYWORD: begin
                if (kw_match) begin
                    n_kw_pos = kw_pos_inc;
                    if (kw_pos_inc >= jbt_pkg::kw_len(r_kw_sel)) begin
                        n_mode = jbt_pkg::MODE_IDLE;
                    end
                end else begin
                    n_mode = jbt_pkg::MODE_ERROR;
                end
            end
            default: begin
                n_mode = r_mode;
            end
        endcase
        // End of message always returns to idle
        if (i_end_of_input) begin
            n_mode     = jbt_pkg::MODE_IDLE;
            n_kw_sel   = 2'd0;
            n_kw_pos   = 3'd0;
            n_kw_first = 8'd0;
        end
    end

    // Result items for this byte
    always_comb begin
        o_pair.first  = jbt_pkg::ITEM_NONE;
        o_pair.second = jbt_pkg::ITEM_NONE;
        item_cnt      = 2'd0;
        unique case (r_mode)
            jbt_pkg::MODE_STRING: begin
                item_cnt = 2'd1;
                if (i_data_byte == jbt_pkg::CH_QUOTE) begin
                    o_pair.first = jbt_pkg::make_item(jbt_pkg::KIND_STRING, 8'd0, 1'b0, 1'b1,
                                                      jbt_pkg::ERR_NONE);
                end else begin
                    o_pair.first = jbt_pkg::make_item(jbt_pkg::KIND_STRING, i_data_byte, 1'b1,
                                                      1'b0, jbt_pkg::ERR_NONE);
                    if (i_end_of_input) begin
                        o_pair.second = jbt_pkg::make_item(4'd0, 8'd0, 1'b0, 1'b0,
                                                           jbt_pkg::ERR_UNTERMINATED);
                        item_cnt      = 2'd2;
                    end
                end
            end
            jbt_pkg::MODE_NUMBER: begin
                item_cnt = 2'd1;
                if (num_char) begin
                    o_pair.first = jbt_pkg::make_item(jbt_pkg::KIND_NUMBER, i_data_byte, 1'b1,
                                                      1'b0, jbt_pkg::ERR_NONE);
                    if (i_end_of_input) begin
                        o_pair.second = jbt_pkg::make_item(jbt_pkg::KIND_NUMBER, 8'd0, 1'b0,
                                                           1'b1, jbt_pkg::ERR_NONE);
                        item_cnt      = 2'd2;
                    end
                end else begin
                    // Close the number, then lex the byte as from idle
                    o_pair.first = jbt_pkg::make_item(jbt_pkg::KIND_NUMBER, 8'd0, 1'b0, 1'b1,
                                                      jbt_pkg::ERR_NONE);
                    if (idle_res.emit) begin
                        o_pair.second = idle_res.item;
                        item_cnt      = 2'd2;
                    end
                end
            end
            jbt_pkg::MODE_KEYWORD: begin
                if (kw_match) begin
                    if (kw_pos_inc >= jbt_pkg::kw_len(r_kw_sel)) begin
                        o_pair.first = jbt_pkg::make_item(jbt_pkg::kw_kind(r_kw_sel), 8'd0,
                                                          1'b0, 1'b1, jbt_pkg::ERR_NONE);
                        item_cnt     = 2'd1;
                    end else if (i_end_of_input) begin
                        o_pair.first = jbt_pkg::make_item(4'd0, r_kw_first, 1'b0, 1'b0,
                                                          jbt_pkg::ERR_UNEXPECTED);
                        item_cnt     = 2'd1;
                    end
                end else begin
                    o_pair.first = jbt_pkg::make_item(4'd0, r_kw_first, 1'b0, 1'b0,
                                                      jbt_pkg::ERR_UNEXPECTED);
                    item_cnt     = 2'd1;
                end
            end
            jbt_pkg::MODE_IDLE: begin
                if (idle_res.emit) begin
                    o_pair.first = idle_res.item;
                    item_cnt     = 2'd1;
                end
            end
            default: begin
                item_cnt = 2'd0;
            end
        endcase
        o_pair.two = item_cnt[1];
    end

    assign o_push = i_accept && (item_cnt != 2'd0);

    // Advance lexer state on each input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= jbt_pkg::MODE_IDLE;
            r_kw_sel   <= 2'd0;
            r_kw_pos   <= 3'd0;
            r_kw_first <= 8'd0;
        end else if (i_accept) begin
            r_mode     <= n_mode;
            r_kw_sel   <= n_kw_sel;
            r_kw_pos   <= n_kw_pos;
            r_kw_first <= n_kw_first;
        end
    end

endmodule

>>> hw/rtl/jbt_out_queue.sv
module jbt_out_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  jbt_pkg::t_pair i_pair,
    output logic           o_full,
    output logic           o_valid,
    input  logic           i_stall,
    output jbt_pkg::t_item o_item,
    output logic           o_last
);

    jbt_pkg::t_pair r_slot [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;
    logic           r_sub;

    jbt_pkg::t_pair head;
    logic           xfer;
    logic           pop;

    assign head    = r_slot[r_rd_ptr];
    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign o_item  = r_sub ? head.second : head.first;
    assign o_last  = head.two ? r_sub : 1'b1;
    assign xfer    = o_valid && !i_stall;
    assign pop     = xfer && o_last;

    // Store each byte's results as one entry
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_pair;
        end
    end

    // Track pointers, fill level and item within the head entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
            r_sub    <= 1'b0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
                r_sub    <= 1'b0;
            end else if (xfer) begin
                r_sub <= 1'b1;
            end
            unique case ({i_push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> hw/rtl/json_byte_tokenizer_top.sv
// Streaming JSON tokenizer.
// Input channel: i_valid / o_stall with i_data_byte and i_end_of_input; a byte
// transfers on a rising edge with i_valid high and o_stall low. Output channel:
// o_valid / i_stall with one token item per transfer; o_last_result marks the
// final item caused by an input byte (each byte gives zero, one or two items).
// A byte is decoded in the cycle it transfers and its items are written to a
// two-entry result queue, whose registered head entry drives the output port.
// Throughput is one byte per cycle while each byte yields at most one item
// and i_stall is low; a byte yielding two items holds its queue entry until
// both are out, the output port moving one item per cycle while not stalled.
// o_stall rises only when both queue entries are occupied; it does not look
// at i_stall combinationally. When the receiver stalls, the current item is
// held unchanged and the queue fills, after which input is held off.
// Synchronous reset (i_rst_n low) empties the queue and returns the lexer to
// idle; the block is ready for input in the first cycle after reset.
module json_byte_tokenizer_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_input,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [3:0] o_token_kind,
    output logic [7:0] o_content_byte,
    output logic       o_content_valid,
    output logic       o_token_end,
    output logic [1:0] o_error_code,
    output logic       o_last_result
);

    logic           in_xfer;
    logic           push;
    logic           full;
    jbt_pkg::t_pair pair;
    jbt_pkg::t_item item;

    assign o_stall = full;
    assign in_xfer = i_valid && !full;

    jbt_lexer u_lexer (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (in_xfer),
        .i_data_byte    (i_data_byte),
        .i_end_of_input (i_end_of_input),
        .o_push         (push),
        .o_pair         (pair)
    );

    jbt_out_queue u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pair  (pair),
        .o_full  (full),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (item),
        .o_last  (o_last_result)
    );

    // Unpack the current item onto the ports
    assign o_token_kind    = item.token_kind;
    assign o_content_byte  = item.content_byte;
    assign o_content_valid = item.content_valid;
    assign o_token_end     = item.token_end;
    assign o_error_code    = item.error_code;

endmodule

>>> hw/rtl/jbt_checker.sv
module jbt_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [3:0] o_token_kind,
    input logic       o_content_valid,
    input logic       o_token_end,
    input logic [1:0] o_error_code
);

    // Reset empties the block and leaves it ready
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !o_stall))
        else $error("output valid or input stalled after reset");

    // A stalled item stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid)
        else $error("output item dropped while stalled");

    // Error items carry no token
    a_error_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_error_code != jbt_pkg::ERR_NONE)) |->
        (!o_content_valid && !o_token_end && (o_token_kind == 4'd0)))
        else $error("error item carries token fields");

    // Content belongs only to strings and numbers
    a_content_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_content_valid) |->
        (((o_token_kind == jbt_pkg::KIND_STRING) || (o_token_kind == jbt_pkg::KIND_NUMBER))
         && !o_token_end))
        else $error("content item of wrong kind");

endmodule

bind json_byte_tokenizer_top jbt_checker u_jbt_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_stall         (o_stall),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_token_kind    (o_token_kind),
    .o_content_valid (o_content_valid),
    .o_token_end     (o_token_end),
    .o_error_code    (o_error_code)
);
